/* src/wssh_pkg.sv */
`default_nettype none

package wssh_pkg;

    // Hash and field widths
    localparam int HASH_W      = 64;
    localparam int BYTE_W      = 8;
    localparam int CL_W        = 4;
    localparam int ZB_W        = 5;
    localparam int WS_W        = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // Default number of word hashes kept
    localparam int MAX_CHAIN_DEF = 8;

    // Register reset values
    localparam logic [CL_W-1:0] CL_RESET = 4'd3;
    localparam logic [ZB_W-1:0] ZB_RESET = 5'd4;

    // Saturation point of the word counter
    localparam logic [WS_W-1:0] WORDS_SEEN_MAX = 4'd15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_BITS    = 2'd1;

    // Input item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    // Word separators
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

    function automatic logic is_separator(input logic [BYTE_W-1:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_NUL);
    endfunction

    // h * 31 + b, wrapping at the hash width
    function automatic logic [HASH_W-1:0] absorb(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
        return (h << 5) - h + {{(HASH_W-BYTE_W){1'b0}}, b};
    endfunction

endpackage

`default_nettype wire

/* src/word_shingle_signature_hasher_core.sv */
`default_nettype none

// Channel  | Dir | Payload                                  | Handshake
// s_*      | in  | tdata: byte_req; tuser: kind              | s_tvalid/s_tready
// m_*      | out | tdata: hash_value; tuser: hash_valid;     | m_tvalid/m_tready
//          |     | tlast: file_end                           |
// cfg_*    | in  | cfg_index, cfg_data                       | cfg_valid/cfg_ready
//
// One item per cycle: each item is handled in the cycle it is accepted, its
// result (if any) is loaded into the output register at the accepting edge.
// The per-word hash lanes (multiply by 31 and add) and the kept-value check
// (lane select, mask test, right shift) sit between state and output register.
// s_tready drops only while a result is held and m_tready is low.
// aresetn is synchronous, active low; no clearing pass is needed.

module word_shingle_signature_hasher_core
    import wssh_pkg::*;
#(
    parameter int MAX_CHAIN = MAX_CHAIN_DEF
) (
    input  wire                    aclk,
    input  wire                    aresetn,

    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [BYTE_W-1:0]      s_tdata,   // [7:0] byte_req
    input  wire                    s_tuser,   // [0] kind

    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [HASH_W-1:0]      m_tdata,   // [63:0] hash_value
    output logic                   m_tuser,   // [0] hash_valid
    output logic                   m_tlast,   // file_end

    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire  [CFG_IDX_W-1:0]   cfg_index,
    input  wire  [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
    localparam logic [5:0] MAX_CHAIN_V = 6'(MAX_CHAIN);

    // State
    logic [HASH_W-1:0] chain_reg  [MAX_CHAIN];
    logic [HASH_W-1:0] chain_next [MAX_CHAIN];
    logic [WS_W-1:0]   words_seen_reg, words_seen_next;
    logic              inside_reg, inside_next;
    logic [CL_W-1:0]   chain_length_reg;
    logic [ZB_W-1:0]   zero_bits_reg;

    // Output register
    logic              m_valid_reg, m_valid_next;
    logic [HASH_W-1:0] m_data_reg, m_data_next;
    logic              m_user_reg, m_user_next;
    logic              m_last_reg, m_last_next;

    logic              s_accept;
    logic              is_eof;
    logic              is_sep;
    logic [5:0]        n_raw;
    logic [5:0]        n_eff;
    logic [5:0]        n_m1;
    logic [HASH_W-1:0] h_sel;
    logic [HASH_W-1:0] zb_mask;
    logic [WS_W-1:0]   ws_inc;
    logic              kept;
    logic [HASH_W-1:0] kept_val;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    assign is_eof = (s_tuser == KIND_EOF);
    assign is_sep = is_separator(s_tdata);

    // Effective chain length: zero counts as one, clip to the lane count
    always_comb begin
        n_raw = {2'b00, chain_length_reg};
        if (n_raw == 6'd0) begin
            n_raw = 6'd1;
        end
        n_eff = (n_raw > MAX_CHAIN_V) ? MAX_CHAIN_V : n_raw;
        n_m1  = n_eff - 6'd1;
    end

    // Check the closing word chain against the zero mask
    always_comb begin
        h_sel    = chain_reg[n_m1[IDX_W-1:0]];
        zb_mask  = (HASH_W'(1) << zero_bits_reg) - HASH_W'(1);
        ws_inc   = (words_seen_reg == WORDS_SEEN_MAX) ? WORDS_SEEN_MAX
                                                      : words_seen_reg + 4'd1;
        kept     = inside_reg && ({2'b00, ws_inc} >= n_eff) && ((h_sel & zb_mask) == '0);
        kept_val = h_sel >> zero_bits_reg;
    end

    // Next state of the word lanes and the output register
    always_comb begin
        for (int k = 0; k < MAX_CHAIN; k++) begin
            chain_next[k] = chain_reg[k];
        end
        words_seen_next = words_seen_reg;
        inside_next     = inside_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        m_last_next     = m_last_reg;

        if (s_accept) begin
            if (is_eof) begin
                // Close any open word, flag the end of the file
                words_seen_next = '0;
                inside_next     = 1'b0;
                m_valid_next    = 1'b1;
                m_user_next     = kept;
                m_data_next     = kept ? kept_val : '0;
                m_last_next     = 1'b1;
            end else if (is_sep) begin
                if (inside_reg) begin
                    words_seen_next = ws_inc;
                    inside_next     = 1'b0;
                end
                if (kept) begin
                    m_valid_next = 1'b1;
                    m_user_next  = 1'b1;
                    m_data_next  = kept_val;
                    m_last_next  = 1'b0;
                end
            end else begin
                // Shift in a fresh lane on a new word, then absorb the byte
                inside_next = 1'b1;
                for (int k = 0; k < MAX_CHAIN; k++) begin
                    if (inside_reg) begin
                        chain_next[k] = absorb(chain_reg[k], s_tdata);
                    end else if (k == 0) begin
                        chain_next[k] = absorb('0, s_tdata);
                    end else begin
                        chain_next[k] = absorb(chain_reg[k-1], s_tdata);
                    end
                end
            end
        end
    end

    // Hold state, configuration and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_CHAIN; k++) begin
                chain_reg[k] <= '0;
            end
            words_seen_reg   <= '0;
            inside_reg       <= 1'b0;
            chain_length_reg <= CL_RESET;
            zero_bits_reg    <= ZB_RESET;
            m_valid_reg      <= 1'b0;
        end else begin
            for (int k = 0; k < MAX_CHAIN; k++) begin
                chain_reg[k] <= chain_next[k];
            end
            words_seen_reg <= words_seen_next;
            inside_reg     <= inside_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CHAIN_LENGTH: chain_length_reg <= cfg_data[CL_W-1:0];
                    CFG_ZERO_BITS:    zero_bits_reg    <= cfg_data[ZB_W-1:0];
                    default: ;
                endcase
            end
        end
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

endmodule

`default_nettype wire

/* tb/sv/word_shingle_signature_hasher_core_tb.sv */
`default_nettype none

module word_shingle_signature_hasher_core_tb;
    import wssh_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 64;
    localparam int MAX_REPORTS  = 50;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data;
    } text_item_t;

    typedef struct packed {
        logic              kept;
        logic [HASH_W-1:0] value;
        logic              fend;
    } sig_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata   = '0;  // [7:0] byte_req
    logic                  s_tuser   = KIND_BYTE;  // [0] kind
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [HASH_W-1:0]     m_tdata;   // [63:0] hash_value
    logic                  m_tuser;   // [0] hash_valid
    logic                  m_tlast;   // file_end
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_CHAIN_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    word_shingle_signature_hasher_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Stimulus and scoreboard storage
    text_item_t  text_q[$];
    sig_result_t sig_q[$];
    sig_result_t sig_head;
    int          n_queued      = 0;
    int          n_accepted    = 0;
    int          mismatches    = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;
    logic        s_taken       = 1'b0;

    // Shadow of the hasher state and its registers
    logic [HASH_W-1:0] lane [MAX_CHAIN_DEF] = '{default: '0};
    logic [WS_W-1:0]   words_done = '0;
    logic              in_word    = 1'b0;
    logic [CL_W-1:0]   chain_reg  = CL_RESET;
    logic [ZB_W-1:0]   zero_reg   = ZB_RESET;

    function automatic logic is_gap(input logic [BYTE_W-1:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_NUL;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Close the open word and test the chain hash of the selected depth
    task automatic close_word(output logic kept, output logic [HASH_W-1:0] v);
        int                n;
        logic [HASH_W-1:0] h;
        logic [HASH_W-1:0] mask;
        in_word = 1'b0;
        if (words_done != WORDS_SEEN_MAX)
            words_done = words_done + 1'b1;
        n = (chain_reg == 0) ? 1 : (chain_reg > MAX_CHAIN_DEF) ? MAX_CHAIN_DEF : chain_reg;
        kept = 1'b0;
        v = '0;
        if (words_done >= n) begin
            h = lane[n-1];
            mask = (64'd1 << zero_reg) - 64'd1;
            if ((h & mask) == '0) begin
                kept = 1'b1;
                v = h >> zero_reg;
            end
        end
    endtask

    // Advance the shadow state by one accepted item and queue any result
    task automatic predict_item(input logic kind, input logic [BYTE_W-1:0] b);
        logic              kept;
        logic [HASH_W-1:0] v;
        kept = 1'b0;
        v = '0;
        if (kind == KIND_EOF) begin
            if (in_word)
                close_word(kept, v);
            words_done = '0;
            in_word = 1'b0;
            sig_q.push_back(sig_result_t'{kept, v, 1'b1});
        end else if (is_gap(b)) begin
            if (in_word) begin
                close_word(kept, v);
                if (kept)
                    sig_q.push_back(sig_result_t'{1'b1, v, 1'b0});
            end
        end else begin
            // a new word shifts every chain up one place
            if (!in_word) begin
                for (int k = MAX_CHAIN_DEF - 1; k > 0; k--)
                    lane[k] = lane[k-1];
                lane[0] = '0;
                in_word = 1'b1;
            end
            for (int k = 0; k < MAX_CHAIN_DEF; k++)
                lane[k] = lane[k] * 64'd31 + {{(HASH_W-BYTE_W){1'b0}}, b};
        end
    endtask

    // Sender: offer the next pending item unless idling
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (text_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tuser  <= text_q[0].kind;
                s_tdata  <= text_q[0].data;
                void'(text_q.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: long hold-off when requested, random stalls otherwise
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Check results against the oldest expectation, then predict new items
    always @(posedge aclk) begin
        s_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (sig_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item kept=%0b value=%h end=%0b",
                                              m_tuser, m_tdata, m_tlast));
                end else begin
                    sig_head = sig_q.pop_front();
                    if (m_tuser !== sig_head.kept)
                        report_mismatch($sformatf("hash_valid %0b, want %0b",
                                                  m_tuser, sig_head.kept));
                    if (m_tdata !== sig_head.value)
                        report_mismatch($sformatf("hash_value %h, want %h",
                                                  m_tdata, sig_head.value));
                    if (m_tlast !== sig_head.fend)
                        report_mismatch($sformatf("file_end %0b, want %0b",
                                                  m_tlast, sig_head.fend));
                end
            end
            if (s_tvalid && s_tready) begin
                predict_item(s_tuser, s_tdata);
                n_accepted++;
            end
        end
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic queue_item(input logic kind, input logic [BYTE_W-1:0] b);
        text_q.push_back(text_item_t'{kind, b});
        n_queued++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_gap();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_NUL;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] word_byte();
        logic [BYTE_W-1:0] b;
        if ($urandom_range(0, 1))
            return BYTE_W'($urandom_range(8'h61, 8'h7A));
        do
            b = BYTE_W'($urandom_range(0, 255));
        while (is_gap(b));
        return b;
    endfunction

    // One file of words; a few files are raw noise bytes
    task automatic add_file(input bit with_eof);
        int nw;
        int len;
        bit noise;
        nw = $urandom_range(1, 18);
        noise = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 3) == 0)
            queue_item(KIND_BYTE, pick_gap());
        for (int w = 0; w < nw; w++) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                queue_item(KIND_BYTE, noise ? BYTE_W'($urandom_range(0, 255)) : word_byte());
            // leave the last word open now and then so the end of file closes it
            if (w != nw - 1 || $urandom_range(0, 1))
                repeat ($urandom_range(1, 2)) queue_item(KIND_BYTE, pick_gap());
        end
        if (with_eof)
            queue_item(KIND_EOF, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_CHAIN_LENGTH)
            chain_reg = val[CL_W-1:0];
        else if (idx == CFG_ZERO_BITS)
            zero_reg = val[ZB_W-1:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge aclk); while (n_accepted != n_queued || sig_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_idle(input idle_mode_t m);
        send_idle_pct  = (m == IDLE_SEND) ? 64 : (m == IDLE_BOTH) ? 14 : 0;
        recv_stall_pct = (m == IDLE_RECV) ? 64 : (m == IDLE_BOTH) ? 14 : 0;
    endtask

    initial begin
        int         chain_set [PHASES] = '{2, 8, 0, 15, 1, 5, 3, 7};
        int         zero_set  [PHASES] = '{1, 0, 31, 2, 3, 31, 4, 0};
        idle_mode_t mode_set  [PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                           IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
        logic [CFG_DATA_W-1:0] val;
        int         start;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: every word end kept, each separator, byte extremes, end of file cases
        set_idle(IDLE_NONE);
        write_reg(CFG_CHAIN_LENGTH, 8'd1);
        write_reg(CFG_ZERO_BITS, 8'd0);
        queue_item(KIND_BYTE, 8'h41);
        queue_item(KIND_BYTE, CH_SPACE);
        queue_item(KIND_BYTE, 8'hFF);
        queue_item(KIND_BYTE, CH_TAB);
        queue_item(KIND_BYTE, 8'h01);
        queue_item(KIND_BYTE, CH_LF);
        queue_item(KIND_BYTE, 8'h7F);
        queue_item(KIND_BYTE, CH_NUL);
        queue_item(KIND_BYTE, CH_SPACE);
        queue_item(KIND_BYTE, 8'h80);
        queue_item(KIND_EOF, 8'h00);
        queue_item(KIND_EOF, 8'hFF);
        wait_drained();

        // Directed: chain length zero, widest zero test, stray upper data bits
        write_reg(CFG_CHAIN_LENGTH, 8'hF0);
        write_reg(CFG_ZERO_BITS, 8'hFF);
        queue_item(KIND_BYTE, 8'h78);
        queue_item(KIND_BYTE, CH_SPACE);
        queue_item(KIND_BYTE, 8'h79);
        queue_item(KIND_EOF, 8'h5A);
        wait_drained();

        // Random phases; the last file of a phase may run on into the next setting
        for (int p = 0; p < PHASES; p++) begin
            val = CFG_DATA_W'($urandom_range(0, 255));
            val[CL_W-1:0] = CL_W'(chain_set[p]);
            write_reg(CFG_CHAIN_LENGTH, val);
            val = CFG_DATA_W'($urandom_range(0, 255));
            val[ZB_W-1:0] = ZB_W'(zero_set[p]);
            write_reg(CFG_ZERO_BITS, val);
            set_idle(mode_set[p]);
            start = n_queued;
            while (n_queued - start < PHASE_ITEMS)
                add_file(1'b1);
            if ($urandom_range(0, 1))
                add_file(1'b0);
            // hold the output off while the sender keeps pushing
            if (p == 0) begin
                @(posedge aclk);
                hold_left = HOLD_CYCLES;
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
src/wssh_pkg.sv
src/word_shingle_signature_hasher_core.sv
tb/sv/word_shingle_signature_hasher_core_tb.sv
